// ===== rtl/grid_min_path_sum_assert.svh =====
// assertion macros used by the grid_min_path_sum top level
`ifndef GRID_MIN_PATH_SUM_ASSERT_SVH
`define GRID_MIN_PATH_SUM_ASSERT_SVH

// property that must hold at every edge outside reset
`define GMPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define GMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gmps_pkg.sv =====
// shared constants and types of the grid minimum path sum block
`timescale 1ns / 1ps
`default_nettype none
package gmps_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int DIM_W     = 7;
  localparam int VAL_W     = 8;
  localparam int COST_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] COST_LIMIT = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [COST_W-1:0] path_sum;
    logic              saturated;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/gmps_cell.sv =====
// one cell of the row cost chain: holds one column cost of the previous row
`timescale 1ns / 1ps
`default_nettype none
module gmps_cell (
  input  wire                          clk_i,
  input  gmps_pkg::cell_ctrl_t         ctrl_i,
  input  wire  [gmps_pkg::COST_W-1:0]  new_cost_i,
  input  wire  [gmps_pkg::COST_W-1:0]  next_cost_i,
  output logic [gmps_pkg::COST_W-1:0]  cost_o
);
  import gmps_pkg::*;

  logic [COST_W-1:0] cost_q;
  logic [COST_W-1:0] cost_d;

  // cell of the last configured column takes the fresh cost, others take their neighbor
  assign cost_d = ctrl_i.load ? new_cost_i : next_cost_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      cost_q <= cost_d;
    end
  end

  assign cost_o = cost_q;

endmodule
`default_nettype wire

// ===== rtl/gmps_cost.sv =====
// cell cost: value plus the cheaper of the upper and left neighbor (the only one on the first row or column), saturated
`timescale 1ns / 1ps
`default_nettype none
module gmps_cost (
  input  wire  [gmps_pkg::VAL_W-1:0]   cell_value_i,
  input  wire  [gmps_pkg::COST_W-1:0]  above_i,
  input  wire  [gmps_pkg::COST_W-1:0]  left_i,
  input  wire                          first_row_i,
  input  wire                          first_col_i,
  output logic [gmps_pkg::COST_W-1:0]  cost_o,
  output logic                         sat_o
);
  import gmps_pkg::*;

  logic [COST_W-1:0] best;
  logic [COST_W:0]   sum;

  always_comb begin
    if (first_row_i && first_col_i) begin
      best = '0;
    end else if (first_row_i) begin
      best = left_i;
    end else if (first_col_i) begin
      best = above_i;
    end else begin
      best = (above_i < left_i) ? above_i : left_i;
    end
    sum    = {1'b0, best} + (COST_W+1)'(cell_value_i);
    sat_o  = (sum >= {1'b0, COST_LIMIT});
    cost_o = sat_o ? COST_LIMIT : sum[COST_W-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/gmps_out_buf.sv =====
// two-entry result queue between the cost datapath and the output channel
`timescale 1ns / 1ps
`default_nettype none
module gmps_out_buf (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  gmps_pkg::result_t  push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output gmps_pkg::result_t  out_data_o
);
  import gmps_pkg::*;

  result_t     entry_q [2];
  logic        rd_q;
  logic        wr_q;
  logic [1:0]  count_q;
  logic        pop;

  assign pop = (count_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= 1'b0;
      wr_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = entry_q[rd_q];

endmodule
`default_nettype wire

// ===== rtl/grid_min_path_sum.sv =====
// top level of the grid minimum path sum block
`timescale 1ns / 1ps
`default_nettype none
`include "grid_min_path_sum_assert.svh"
// Grid cells arrive in row-major order, one 8-bit cost per input beat, on a
// rows by columns grid (register 0 rows, register 1 columns; 0 acts as 1, values
// above 64 act as 64). The block takes one beat every cycle while input stall
// is low, with no gaps between grids: each cell needs one min, one add and one
// saturation compare against the left neighbor and the cost stored for its
// column. After the bottom-right cell a result beat with the cheapest right/down
// path cost is written to a two-entry output queue, offered once any earlier
// result has left it. Costs saturate at 65535 and the saturated flag tells that
// it happened somewhere in that grid. Input stall rises only when both queue
// entries wait. Any write to register 0 or 1 restarts the grid. There is no
// clearing pass after reset; the row costs live in a chain of 64 cells.
module grid_min_path_sum (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_we_i,
  input  wire  [gmps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [gmps_pkg::DIM_W-1:0]       cfg_data_i,
  // cell input channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [gmps_pkg::VAL_W-1:0]       cell_value_i,
  // result output channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [gmps_pkg::COST_W-1:0]      path_sum_o,
  output logic                             saturated_o
);
  import gmps_pkg::*;

  // configuration and walk state
  logic [DIM_W-1:0]  rows_cfg_q;
  logic [DIM_W-1:0]  cols_cfg_q;
  logic [COST_W-1:0] left_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              ovf_q;

  logic [COL_W-1:0]  cols_m1;
  logic [ROW_W-1:0]  rows_m1;
  logic              accept;
  logic              last_col;
  logic              last_row;
  logic              push;
  logic              cfg_hit;

  logic [COST_W-1:0] new_cost;
  logic              new_sat;
  result_t           push_data;
  result_t           out_data;
  logic              buf_full;

  // chain taps: tap[0] is the cost of the current column one row up
  logic [COST_W-1:0] tap [MAX_COLS];
  cell_ctrl_t        cell_ctrl [MAX_COLS];

  // clamp dimensions into 1..max, kept as last index
  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_m1 = '0;
    end else if (int'(cols_cfg_q) > MAX_COLS) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(cols_cfg_q - DIM_W'(1));
    end
    if (rows_cfg_q == '0) begin
      rows_m1 = '0;
    end else if (int'(rows_cfg_q) > MAX_ROWS) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(rows_cfg_q - DIM_W'(1));
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign last_col = (col_q == cols_m1);
  assign last_row = (row_q == rows_m1);
  assign push     = accept && last_col && last_row;
  assign cfg_hit  = cfg_we_i && ((cfg_index_i == CFG_NUM_ROWS) ||
                                 (cfg_index_i == CFG_NUM_COLS));

  gmps_cost u_cost (
    .cell_value_i (cell_value_i),
    .above_i      (tap[0]),
    .left_i       (left_q),
    .first_row_i  (row_q == '0),
    .first_col_i  (col_q == '0),
    .cost_o       (new_cost),
    .sat_o        (new_sat)
  );

  // row cost chain: shifts toward cell 0 on every beat, the new cost enters
  // at the cell of the last column so it reaches cell 0 one row later
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    assign cell_ctrl[i].shift = accept;
    assign cell_ctrl[i].load  = (cols_m1 == COL_W'(i));
    if (i == MAX_COLS - 1) begin : g_tail
      gmps_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .new_cost_i  (new_cost),
        .next_cost_i (new_cost),
        .cost_o      (tap[i])
      );
    end else begin : g_body
      gmps_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .new_cost_i  (new_cost),
        .next_cost_i (tap[i+1]),
        .cost_o      (tap[i])
      );
    end
  end

  // grid walk and configuration, writes to unused indexes leave the walk alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DIM_W'(1);
      cols_cfg_q <= DIM_W'(1);
      left_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      ovf_q      <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index_i == CFG_NUM_ROWS) begin
        rows_cfg_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_NUM_COLS) begin
        cols_cfg_q <= cfg_data_i;
      end
      left_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      ovf_q <= push ? 1'b0 : (ovf_q | new_sat);
      if (last_col) begin
        left_q <= '0;
        col_q  <= '0;
        row_q  <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        left_q <= new_cost;
        col_q  <= col_q + COL_W'(1);
      end
    end
  end

  assign push_data.path_sum  = new_cost;
  assign push_data.saturated = ovf_q | new_sat;

  gmps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign in_stall_o  = buf_full;
  assign path_sum_o  = out_data.path_sum;
  assign saturated_o = out_data.saturated;

  // walk stays inside the configured grid
  `GMPS_ASSERT(a_col_range, col_q <= cols_m1, "column index beyond grid width")
  `GMPS_ASSERT(a_row_range, row_q <= rows_m1, "row index beyond grid height")
  // a full queue still has a result on offer
  `GMPS_ASSERT(a_full_valid, !in_stall_o || out_valid_o, "input stalled with no result")
  // a beat inside a row moves one column right
  `GMPS_ASSERT_NEXT(a_col_step, accept && !cfg_we_i && !last_col,
                    col_q == $past(col_q) + COL_W'(1), "column did not advance")
  // a finished grid leaves the walk at the top-left cell
  `GMPS_ASSERT_NEXT(a_grid_end, push && !cfg_we_i,
                    (col_q == '0) && (row_q == '0) && !ovf_q, "grid did not restart")

endmodule
`default_nettype wire
